### rtl/smm_pkg.sv
// Shared types and constants for the square matrix multiply block.
package smm_pkg;

  localparam int MAX_N   = 64;
  localparam int ELEM_W  = 16;
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 38;
  localparam int IDX_W   = $clog2(MAX_N);
  localparam int NSZ_W   = 7;
  localparam int PROD_W  = 2 * ELEM_W;

  typedef enum logic [1:0] {
    REQ_WR_A = 2'd0,
    REQ_WR_B = 2'd1,
    REQ_CALC = 2'd2
  } req_t;

  // operand token passed down the cell chain
  typedef struct packed {
    logic                     vld;
    logic                     first;
    logic                     last;
    logic [IDX_W-1:0]         k;
    logic signed [ELEM_W-1:0] a;
  } tok_t;

  // drain control for the sum shift chain
  typedef struct packed {
    logic load;
    logic shift;
  } drain_t;

endpackage

### rtl/smm_cell.sv
// One column cell: B column store, multiply-accumulate and sum shift stage.
module smm_cell
  import smm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     b_we,
  input  logic [IDX_W-1:0]         b_waddr,
  input  logic signed [ELEM_W-1:0] b_wdata,
  input  tok_t                     tok_in,
  output tok_t                     tok_out,
  input  drain_t                   drain,
  input  logic signed [SUM_W-1:0]  sum_in,
  output logic signed [SUM_W-1:0]  sum_out,
  output logic                     done
);

  logic signed [ELEM_W-1:0] b_mem [MAX_N];
  logic signed [ELEM_W-1:0] b_rd_r;
  tok_t                     tok_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     p_vld_r;
  logic                     p_first_r;
  logic                     p_last_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     done_r;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= b_wdata;
    end
    b_rd_r <= b_mem[tok_in.k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      p_vld_r   <= 1'b0;
      p_first_r <= 1'b0;
      p_last_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      tok_r     <= tok_in;
      p_vld_r   <= tok_r.vld;
      p_first_r <= tok_r.first;
      p_last_r  <= tok_r.last;
      done_r    <= p_vld_r && p_last_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (p_vld_r) begin
      if (p_first_r) begin
        acc_nxt = SUM_W'(prod_r);
      end else begin
        acc_nxt = acc_r + SUM_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tok_r.a * b_rd_r;
    acc_r  <= acc_nxt;
    if (drain.load) begin
      sum_r <= acc_r;
    end else if (drain.shift) begin
      sum_r <= sum_in;
    end
  end

  assign tok_out = tok_r;
  assign sum_out = sum_r;
  assign done    = done_r;

endmodule

### rtl/square_matrix_multiply.sv
// Top level: request decode, A store, sequencer and the chain of column cells.
//
//  channel  | handshake           | words
//  ---------+---------------------+----------------------------------------------
//  input    | start & !busy       | in_req_type, in_row, in_col, in_value
//  result   | out_strobe (1 cyc)  | out_row, out_col, out_sum, out_last
//  config   | cfg_we              | cfg_wdata (matrix_size)
//
// A or B write: busy stays low.
// Compute row: busy while the FEED state feeds A[i][k] into the chain, the WAIT state
// covers the token walk to cell n-1 plus the read/multiply/accumulate stages, and
// the DRAIN state shifts the sums out one word a cycle; the last word shows in the
// first idle cycle.
// Compute outside n and unknown request types are accepted and emit nothing.
// Synchronous active-low reset; no clearing pass. The receiver cannot stall.
module square_matrix_multiply
  import smm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     cfg_we,
  input  logic [NSZ_W-1:0]         cfg_wdata,
  output logic                     out_strobe,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  out_sum,
  output logic                     out_last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FEED  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NSZ_W-1:0]         msize_r;
  logic [NSZ_W-1:0]         n_eff;
  logic [NSZ_W-1:0]         n_m1;
  logic [IDX_W-1:0]         row_r, row_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         c_r, c_nxt;
  logic                     accept;
  logic                     wr_a;
  logic                     wr_b;
  logic signed [ELEM_W-1:0] elem;
  logic signed [ELEM_W-1:0] a_mem [MAX_N*MAX_N];
  logic signed [ELEM_W-1:0] a_rd_r;
  tok_t                     feed_r;
  tok_t                     tok_head;
  tok_t                     tok_link [MAX_N];
  logic signed [SUM_W-1:0]  sum_link [MAX_N];
  logic [MAX_N-1:0]         done_v;
  logic [MAX_N-1:0]         b_we;
  drain_t                   drain;

  logic                     out_strobe_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic                     out_last_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign wr_a   = accept && (in_req_type == REQ_WR_A);
  assign wr_b   = accept && (in_req_type == REQ_WR_B);
  assign elem   = ELEM_W'(in_value);

  // matrix size clamp to 1..MAX_N
  always_comb begin
    n_eff = msize_r;
    if (msize_r == '0) begin
      n_eff = NSZ_W'(1);
    end else if (msize_r > NSZ_W'(MAX_N)) begin
      n_eff = NSZ_W'(MAX_N);
    end
    n_m1 = n_eff - NSZ_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_r <= NSZ_W'(MAX_N);
    end else if (cfg_we) begin
      msize_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[{in_row, in_col}] <= elem;
    end
    a_rd_r <= a_mem[{row_r, k_r}];
  end

  always_comb begin
    for (int j = 0; j < MAX_N; j++) begin
      b_we[j] = wr_b && (in_col == IDX_W'(j));
    end
  end

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    k_nxt       = k_r;
    c_nxt       = c_r;
    drain.load  = 1'b0;
    drain.shift = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_CALC) && ({1'b0, in_row} < n_eff)) begin
          row_nxt   = in_row;
          k_nxt     = '0;
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        k_nxt = k_r + IDX_W'(1);
        if ({1'b0, k_r} == n_m1) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (done_v[n_m1[IDX_W-1:0]]) begin
          drain.load = 1'b1;
          c_nxt      = '0;
          state_nxt  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain.shift = 1'b1;
        c_nxt       = c_r + IDX_W'(1);
        if ({1'b0, c_r} == n_m1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      feed_r       <= '0;
      out_strobe_r <= 1'b0;
      k_r          <= '0;
      c_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      c_r          <= c_nxt;
      feed_r.vld   <= (state_r == ST_FEED);
      feed_r.first <= (k_r == '0);
      feed_r.last  <= ({1'b0, k_r} == n_m1);
      feed_r.k     <= k_r;
      feed_r.a     <= '0;
      out_strobe_r <= (state_r == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    out_row_r  <= row_r;
    out_col_r  <= c_r;
    out_sum_r  <= sum_link[0];
    out_last_r <= ({1'b0, c_r} == n_m1);
  end

  always_comb begin
    tok_head   = feed_r;
    tok_head.a = a_rd_r;
  end

  for (genvar j = 0; j < MAX_N; j++) begin : g_cell
    tok_t                    tin;
    logic signed [SUM_W-1:0] sin;

    if (j == 0) begin : g_head
      assign tin = tok_head;
    end else begin : g_mid
      assign tin = tok_link[j-1];
    end

    if (j == MAX_N - 1) begin : g_tail
      assign sin = '0;
    end else begin : g_body
      assign sin = sum_link[j+1];
    end

    smm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .b_we    (b_we[j]),
      .b_waddr (in_row),
      .b_wdata (elem),
      .tok_in  (tin),
      .tok_out (tok_link[j]),
      .drain   (drain),
      .sum_in  (sin),
      .sum_out (sum_link[j]),
      .done    (done_v[j])
    );
  end

  assign out_strobe = out_strobe_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_sum    = out_sum_r;
  assign out_last   = out_last_r;

endmodule

### rtl/smm_checker.sv
// Port-level checker for the square matrix multiply block, with its bind.
module smm_checker
  import smm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_req_type,
  input logic [IDX_W-1:0]         in_row,
  input logic [IDX_W-1:0]         in_col,
  input logic signed [VAL_W-1:0]  in_value,
  input logic                     cfg_we,
  input logic [NSZ_W-1:0]         cfg_wdata,
  input logic                     out_strobe,
  input logic [IDX_W-1:0]         out_row,
  input logic [IDX_W-1:0]         out_col,
  input logic signed [SUM_W-1:0]  out_sum,
  input logic                     out_last
);

  // a row goes out back to back
  a_row_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("row burst broken");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=>
      (out_col == $past(out_col) + IDX_W'(1)) && (out_row == $past(out_row)))
    else $error("column or row step wrong");

  a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("idle in the middle of a row");

  // element writes never stall the port
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_req_type == REQ_WR_A) || (in_req_type == REQ_WR_B)) |=> !busy)
    else $error("write held the port");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_col == '0) |-> $past(busy))
    else $error("row started without a compute");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (.*);

### tb/square_matrix_multiply_tb.sv
// Self-checking testbench for square_matrix_multiply: store fill, directed table, then random phases.
module square_matrix_multiply_tb
  import smm_pkg::*;
;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SETTLE      = 3 * MAX_N + 64;
  localparam int STALL_LIMIT = 5000;
  localparam int N_PHASES    = 11;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    logic                set_size;
    logic [NSZ_W-1:0]    size;
    logic [1:0]          rq;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [VAL_W-1:0]    value;
    chk_t                chk;
    logic [SUM_W-1:0]    sum;
  } dir_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } c_word_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_req_type;
  logic [IDX_W-1:0]        in_row;
  logic [IDX_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    cfg_we;
  logic [NSZ_W-1:0]        cfg_wdata;
  logic                    out_strobe;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] out_sum;
  logic                    out_last;

  logic signed [ELEM_W-1:0] a_mem [MAX_N*MAX_N];
  logic signed [ELEM_W-1:0] b_mem [MAX_N*MAX_N];
  logic [NSZ_W-1:0]         size_reg;
  c_word_t                  c_row_q [$];
  c_word_t                  exp_w;
  int                       err_cnt;
  int unsigned              stall_cyc;
  bit                       no_gaps;

  int ph_size  [N_PHASES] = '{1, 2, 3, 4, 7, 16, 64, 127, 33, 5, 8};
  int ph_words [N_PHASES] = '{40, 50, 50, 50, 50, 60, 20, 15, 40, 50, 40};

  dir_row_t dir_tab [24] = '{
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd63, 6'd0,  16'h0000, CHK_PRED, 38'd0},
    '{1'b1, 7'd1, REQ_WR_A, 6'd0,  6'd0,  16'h0100, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_WR_B, 6'd0,  6'd0,  16'h0100, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  38'sd65536},
    '{1'b0, 7'd0, REQ_WR_A, 6'd0,  6'd0,  16'h8000, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_WR_B, 6'd0,  6'd0,  16'h8000, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  38'sd1073741824},
    '{1'b0, 7'd0, REQ_WR_A, 6'd0,  6'd0,  16'h7fff, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  -38'sd1073709056},
    '{1'b0, 7'd0, REQ_WR_B, 6'd0,  6'd0,  16'h7fff, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  38'sd1073676289},
    '{1'b0, 7'd0, REQ_WR_A, 6'd63, 6'd63, 16'hffff, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_WR_B, 6'd63, 6'd0,  16'h5555, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd1,  6'd0,  16'h0000, CHK_NONE, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd63, 6'd63, 16'hffff, CHK_NONE, 38'd0},
    '{1'b0, 7'd0, REQ_NONE, 6'd0,  6'd63, 16'hffff, CHK_NONE, 38'd0},
    '{1'b1, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  38'sd1073676289},
    '{1'b0, 7'd0, REQ_CALC, 6'd1,  6'd0,  16'h0000, CHK_NONE, 38'd0},
    '{1'b0, 7'd0, REQ_WR_A, 6'd0,  6'd0,  16'hffff, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_WR_B, 6'd0,  6'd0,  16'hffff, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_ONE,  38'sd1},
    '{1'b1, 7'd2, REQ_CALC, 6'd1,  6'd0,  16'h0000, CHK_PRED, 38'd0},
    '{1'b0, 7'd0, REQ_CALC, 6'd0,  6'd0,  16'h0000, CHK_PRED, 38'd0}
  };

  square_matrix_multiply i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_strobe  (out_strobe),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_sum     (out_sum),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int order_n();
    if (size_reg == 0) return 1;
    if (int'(size_reg) > MAX_N) return MAX_N;
    return int'(size_reg);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Model store update on writes, and C row prediction: exact dot products at the current order
  task automatic predict_c_row(input logic [1:0] rq, input logic [IDX_W-1:0] r,
                               input logic [IDX_W-1:0] c,
                               input logic signed [VAL_W-1:0] v);
    int ne;
    longint acc;
    c_word_t w;
    ne = order_n();
    if (rq == REQ_WR_A) begin
      a_mem[{r, c}] = v;
    end else if (rq == REQ_WR_B) begin
      b_mem[{r, c}] = v;
    end else if (rq == REQ_CALC && int'(r) < ne) begin
      for (int j = 0; j < ne; j++) begin
        acc = 0;
        for (int k = 0; k < ne; k++)
          acc += longint'(a_mem[{r, IDX_W'(k)}]) * longint'(b_mem[{IDX_W'(k), IDX_W'(j)}]);
        w.row  = r;
        w.col  = IDX_W'(j);
        w.sum  = acc[SUM_W-1:0];
        w.last = (j == ne - 1);
        c_row_q.push_back(w);
      end
    end
  endtask

  task automatic send_word(input logic [1:0] rq, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
                           input chk_t chk, input logic signed [SUM_W-1:0] tsum);
    int gap;
    c_word_t w;
    gap = pick_gap();
    repeat (gap) begin
      start       <= 1'b0;
      in_req_type <= 2'($urandom);
      in_row      <= IDX_W'($urandom);
      in_col      <= IDX_W'($urandom);
      in_value    <= VAL_W'($urandom);
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= rq;
    in_row      <= r;
    in_col      <= c;
    in_value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (chk)
      CHK_PRED: predict_c_row(rq, r, c, v);
      CHK_ONE: begin
        w.row  = r;
        w.col  = '0;
        w.sum  = tsum;
        w.last = 1'b1;
        c_row_q.push_back(w);
      end
      default: ;
    endcase
  endtask

  task automatic write_size(input logic [NSZ_W-1:0] v);
    start <= 1'b0;
    while (c_row_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg = v;
  endtask

  task automatic run_phase(input int n_words);
    int done, ne, pick;
    logic [1:0] rq;
    logic [IDX_W-1:0] r, c;
    logic signed [VAL_W-1:0] v;
    done = 0;
    ne   = order_n();
    while (done < n_words) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
      v = pick_value();
      if (pick < 40) begin
        rq = REQ_CALC;
        if ($urandom_range(0, 9) != 0) r = IDX_W'($urandom_range(0, ne - 1));
      end else if (pick < 96) begin
        rq = (pick < 68) ? REQ_WR_A : REQ_WR_B;
        if ($urandom_range(0, 4) != 0) begin
          r = IDX_W'($urandom_range(0, ne - 1));
          c = IDX_W'($urandom_range(0, ne - 1));
        end
      end else begin
        rq = REQ_NONE;
      end
      send_word(rq, r, c, v, CHK_PRED, '0);
      if (rq != REQ_NONE && !(rq == REQ_CALC && int'(r) >= ne)) done++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) stall_cyc <= 0;
    else stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= STALL_LIMIT) begin
      $display("square_matrix_multiply_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (c_row_q.size() == 0) begin
        $display("%0t: unexpected word row %0d col %0d sum %0d last %0d", $time,
                 out_row, out_col, out_sum, out_last);
        err_cnt++;
      end else begin
        exp_w = c_row_q.pop_front();
        if (out_row !== exp_w.row) begin
          $display("%0t: out_row expected %0d got %0d", $time, exp_w.row, out_row);
          err_cnt++;
        end
        if (out_col !== exp_w.col) begin
          $display("%0t: out_col expected %0d got %0d", $time, exp_w.col, out_col);
          err_cnt++;
        end
        if (out_sum !== exp_w.sum) begin
          $display("%0t: out_sum expected %0d got %0d", $time, exp_w.sum, out_sum);
          err_cnt++;
        end
        if (out_last !== exp_w.last) begin
          $display("%0t: out_last expected %0d got %0d", $time, exp_w.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = '0;
    in_row      = '0;
    in_col      = '0;
    in_value    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    size_reg    = NSZ_W'(MAX_N);
    err_cnt     = 0;
    stall_cyc   = 0;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill both stores so every later read hits a written entry
    for (int ri = 0; ri < MAX_N; ri++) begin
      no_gaps = $urandom_range(0, 1);
      for (int ci = 0; ci < MAX_N; ci++) begin
        send_word(REQ_WR_A, IDX_W'(ri), IDX_W'(ci), pick_value(), CHK_PRED, '0);
        send_word(REQ_WR_B, IDX_W'(ri), IDX_W'(ci), pick_value(), CHK_PRED, '0);
      end
    end
    no_gaps = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_size) write_size(dir_tab[i].size);
      send_word(dir_tab[i].rq, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value,
                dir_tab[i].chk, dir_tab[i].sum);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_size(NSZ_W'(ph_size[p]));
      run_phase(ph_words[p]);
    end

    start <= 1'b0;
    while (c_row_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (c_row_q.size() != 0) begin
      $display("%0t: %0d expected words never seen", $time, c_row_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("square_matrix_multiply_tb: clean");
    end else begin
      $display("square_matrix_multiply_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/smm_pkg.sv
rtl/smm_cell.sv
rtl/square_matrix_multiply.sv
rtl/smm_checker.sv
tb/square_matrix_multiply_tb.sv
